### src/igfvs_pkg.sv
package igfvs_pkg;

   localparam int MaxIntervals = 32;
   localparam int CoordWidth = 16;
   localparam int IdWidth = 10;

   typedef struct packed {
      logic load_start;
      logic load_end;
      logic sort_init;
      logic sort_issue;
      logic sw_rd_order;
      logic sw_rd_info;
      logic sw_proc;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic has_room;
      logic final_seen;
      logic set_empty;
      logic sort_done;
      logic sw_last;
      logic out_free;
   } status_type;

endpackage

### src/igfvs_ctrl.sv
module igfvs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_final_item,
   output logic                 req_stall,
   input  igfvs_pkg::status_type sts,
   output igfvs_pkg::cmd_type    cmd
);
   import igfvs_pkg::*;

   typedef enum logic [6:0] {
      S_LOAD   = 7'b0000001,
      S_LOAD2  = 7'b0000010,
      S_START  = 7'b0000100,
      S_SORT   = 7'b0001000,
      S_SWADDR = 7'b0010000,
      S_SWCODE = 7'b0100000,
      S_SWPROC = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      fin_ff, fin_in;
   logic      accept;

   assign req_stall = (state_ff != S_LOAD) || fin_ff;
   assign accept = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      fin_in = fin_ff;
      cmd = '0;
      case (state_ff)
         S_LOAD: begin
            if (fin_ff) begin
               if (sts.out_free) begin
                  cmd.finish = 1'b1;
                  fin_in = 1'b0;
               end
            end else if (accept) begin
               cmd.load_start = 1'b1;
               if (sts.has_room) begin
                  state_in = S_LOAD2;
               end else if (req_final_item) begin
                  state_in = S_START;
               end
            end
         end
         S_LOAD2: begin
            cmd.load_end = 1'b1;
            state_in = sts.final_seen ? S_START : S_LOAD;
         end
         S_START: begin
            cmd.sort_init = 1'b1;
            if (sts.set_empty) begin
               state_in = S_LOAD;
               fin_in = 1'b1;
            end else begin
               state_in = S_SORT;
            end
         end
         S_SORT: begin
            cmd.sort_issue = 1'b1;
            if (sts.sort_done) begin
               state_in = S_SWADDR;
            end
         end
         S_SWADDR: begin
            cmd.sw_rd_order = 1'b1;
            state_in = S_SWCODE;
         end
         S_SWCODE: begin
            cmd.sw_rd_info = 1'b1;
            state_in = S_SWPROC;
         end
         S_SWPROC: begin
            if (sts.out_free) begin
               cmd.sw_proc = 1'b1;
               if (sts.sw_last) begin
                  state_in = S_LOAD;
                  fin_in = 1'b1;
               end else begin
                  state_in = S_SWADDR;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         fin_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fin_ff <= fin_in;
      end
   end

endmodule

### src/igfvs_dp.sv
module igfvs_dp #(
   parameter int MAX_INTERVALS = igfvs_pkg::MaxIntervals,
   parameter int COORD_WIDTH = igfvs_pkg::CoordWidth
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [COORD_WIDTH-1:0]          req_start_pos,
   input  logic [COORD_WIDTH-1:0]          req_end_pos,
   input  logic [igfvs_pkg::IdWidth-1:0]   req_ident,
   input  logic                            req_final_item,
   input  igfvs_pkg::cmd_type              cmd,
   output igfvs_pkg::status_type           sts,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [igfvs_pkg::IdWidth-1:0]   rsp_member_id,
   output logic                            rsp_empty_set,
   output logic                            rsp_overflow,
   output logic                            rsp_run_end
);
   import igfvs_pkg::*;

   localparam int IW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
   localparam int CW = IW + 1;
   localparam int Depth2 = 2 * MAX_INTERVALS;

   logic [COORD_WIDTH-1:0] coord_mem [Depth2];
   logic [CW-1:0]          order_mem [Depth2];
   logic [IW-1:0]          rank_mem  [MAX_INTERVALS];
   logic [IdWidth-1:0]     ident_mem [MAX_INTERVALS];

   logic [IW:0]            count_ff;
   logic                   ovf_ff;
   logic                   final_ff;
   logic [COORD_WIDTH-1:0] endp_ff;
   logic [CW-1:0]          last_code;

   logic [CW-1:0]          a_ff, b_ff;
   logic                   issued_ff;
   logic                   s1_vld_ff, s1_last_ff;
   logic [CW-1:0]          s1_a_ff, s1_b_ff;
   logic [COORD_WIDTH-1:0] rd_a_ff, rd_b_ff;
   logic [CW-1:0]          pos_ff;
   logic [IW-1:0]          rank_ff;
   logic                   b_first;
   logic [CW-1:0]          pos_sum;
   logic [IW-1:0]          rank_sum;
   logic                   issue;

   logic [CW-1:0]          i_ff;
   logic [CW-1:0]          code_ff;
   logic [IW-1:0]          e_ff;
   logic                   kind_ff;
   logic [IW-1:0]          rk_ff;
   logic [IdWidth-1:0]     idn_ff;

   logic                   hv_ff, lv_ff;
   logic [IW-1:0]          ah_e_ff, al_e_ff, ah_r_ff, al_r_ff;
   logic [IdWidth-1:0]     ah_id_ff, al_id_ff;
   logic                   pend_vld_ff;
   logic [IdWidth-1:0]     pend_id_ff;

   logic                   emit;
   logic [IdWidth-1:0]     emit_id;
   logic                   nl, nh;

   logic                   out_vld_ff, out_empty_ff, out_ovf_ff, out_end_ff;
   logic [IdWidth-1:0]     out_id_ff;
   logic                   out_free;

   assign last_code = CW'({count_ff, 1'b0} - 1'b1);
   assign out_free = !out_vld_ff || !rsp_stall;
   assign issue = cmd.sort_issue && !issued_ff;

   assign sts.has_room = (count_ff < (IW+1)'(MAX_INTERVALS));
   assign sts.final_seen = final_ff;
   assign sts.set_empty = (count_ff == '0);
   assign sts.sort_done = issued_ff && !s1_vld_ff;
   assign sts.sw_last = (i_ff == last_code);
   assign sts.out_free = out_free;

   assign b_first = (rd_b_ff < rd_a_ff) ||
                    ((rd_b_ff == rd_a_ff) &&
                     ((s1_b_ff[0] < s1_a_ff[0]) ||
                      ((s1_b_ff[0] == s1_a_ff[0]) && (s1_b_ff < s1_a_ff))));
   assign pos_sum = pos_ff + CW'(b_first);
   assign rank_sum = rank_ff + IW'(b_first && s1_b_ff[0]);

   always_comb begin
      emit = 1'b0;
      emit_id = idn_ff;
      if (!kind_ff && hv_ff && lv_ff) begin
         emit = 1'b1;
         if (rk_ff < ah_r_ff) begin
            emit_id = ah_id_ff;
         end
      end
      nl = lv_ff && (al_e_ff != e_ff);
      nh = hv_ff && (ah_e_ff != e_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.load_start && sts.has_room) begin
         coord_mem[{count_ff[IW-1:0], 1'b0}] <= req_start_pos;
         ident_mem[count_ff[IW-1:0]] <= req_ident;
      end else if (cmd.load_end) begin
         coord_mem[{count_ff[IW-1:0], 1'b1}] <= endp_ff;
      end
      if (issue) begin
         rd_a_ff <= coord_mem[a_ff];
         rd_b_ff <= coord_mem[b_ff];
      end
      if (s1_vld_ff && s1_last_ff) begin
         order_mem[pos_sum] <= s1_a_ff;
         if (s1_a_ff[0]) begin
            rank_mem[s1_a_ff[CW-1:1]] <= rank_sum;
         end
      end
      if (cmd.sw_rd_order) begin
         code_ff <= order_mem[i_ff];
      end
      if (cmd.sw_rd_info) begin
         rk_ff <= rank_mem[code_ff[CW-1:1]];
         idn_ff <= ident_mem[code_ff[CW-1:1]];
         e_ff <= code_ff[CW-1:1];
         kind_ff <= code_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_start) begin
         endp_ff <= req_end_pos;
      end
      if (issue) begin
         s1_a_ff <= a_ff;
         s1_b_ff <= b_ff;
         s1_last_ff <= (b_ff == last_code);
      end
      if (s1_vld_ff) begin
         pos_ff <= s1_last_ff ? '0 : pos_sum;
         rank_ff <= s1_last_ff ? '0 : rank_sum;
      end
      if (cmd.sort_init) begin
         pos_ff <= '0;
         rank_ff <= '0;
      end
      if (cmd.sw_proc) begin
         if (!kind_ff) begin
            if (!hv_ff) begin
               ah_e_ff <= e_ff; ah_r_ff <= rk_ff; ah_id_ff <= idn_ff;
            end else if (!lv_ff) begin
               if (rk_ff > ah_r_ff) begin
                  al_e_ff <= ah_e_ff; al_r_ff <= ah_r_ff; al_id_ff <= ah_id_ff;
                  ah_e_ff <= e_ff; ah_r_ff <= rk_ff; ah_id_ff <= idn_ff;
               end else begin
                  al_e_ff <= e_ff; al_r_ff <= rk_ff; al_id_ff <= idn_ff;
               end
            end else if (rk_ff < al_r_ff) begin
               ah_e_ff <= al_e_ff; ah_r_ff <= al_r_ff; ah_id_ff <= al_id_ff;
               al_e_ff <= e_ff; al_r_ff <= rk_ff; al_id_ff <= idn_ff;
            end else if (rk_ff < ah_r_ff) begin
               ah_e_ff <= e_ff; ah_r_ff <= rk_ff; ah_id_ff <= idn_ff;
            end
         end else if (nl && !nh) begin
            ah_e_ff <= al_e_ff; ah_r_ff <= al_r_ff; ah_id_ff <= al_id_ff;
         end
         if (emit) begin
            pend_id_ff <= emit_id;
         end
      end
      if (cmd.finish) begin
         out_id_ff <= pend_vld_ff ? pend_id_ff : '0;
         out_empty_ff <= !pend_vld_ff;
         out_ovf_ff <= ovf_ff;
         out_end_ff <= 1'b1;
      end else if (cmd.sw_proc && emit && pend_vld_ff) begin
         out_id_ff <= pend_id_ff;
         out_empty_ff <= 1'b0;
         out_ovf_ff <= ovf_ff;
         out_end_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff <= 1'b0;
         final_ff <= 1'b0;
         a_ff <= '0;
         b_ff <= '0;
         issued_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
         i_ff <= '0;
         hv_ff <= 1'b0;
         lv_ff <= 1'b0;
         pend_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (cmd.load_start) begin
            final_ff <= req_final_item;
            if (!sts.has_room) begin
               ovf_ff <= 1'b1;
            end
         end
         if (cmd.load_end) begin
            count_ff <= count_ff + 1'b1;
         end
         s1_vld_ff <= issue;
         if (cmd.sort_init) begin
            a_ff <= '0;
            b_ff <= '0;
            issued_ff <= 1'b0;
            i_ff <= '0;
            hv_ff <= 1'b0;
            lv_ff <= 1'b0;
            pend_vld_ff <= 1'b0;
         end else if (issue) begin
            if (b_ff == last_code) begin
               b_ff <= '0;
               if (a_ff == last_code) begin
                  issued_ff <= 1'b1;
               end else begin
                  a_ff <= a_ff + 1'b1;
               end
            end else begin
               b_ff <= b_ff + 1'b1;
            end
         end
         if (cmd.sw_proc) begin
            i_ff <= i_ff + 1'b1;
            if (!kind_ff) begin
               if (!hv_ff) begin
                  hv_ff <= 1'b1;
               end else if (!lv_ff) begin
                  lv_ff <= 1'b1;
               end
            end else if (nl && !nh) begin
               hv_ff <= 1'b1;
               lv_ff <= 1'b0;
            end else begin
               hv_ff <= nh;
               lv_ff <= nl;
            end
            if (emit) begin
               pend_vld_ff <= 1'b1;
            end
         end
         if (cmd.finish) begin
            count_ff <= '0;
            ovf_ff <= 1'b0;
            final_ff <= 1'b0;
            pend_vld_ff <= 1'b0;
            hv_ff <= 1'b0;
            lv_ff <= 1'b0;
         end
         if (cmd.finish || (cmd.sw_proc && emit && pend_vld_ff)) begin
            out_vld_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_member_id = out_id_ff;
   assign rsp_empty_set = out_empty_ff;
   assign rsp_overflow = out_ovf_ff;
   assign rsp_run_end = out_end_ff;

endmodule

### src/interval_graph_fvs_sweep.sv
// A stored interval passes S_LOAD, then S_LOAD2; one beyond the store sets overflow.
// After the final transaction the block ranks and sorts endpoints by pairwise compare
// of all stored endpoints, over two read ports of the coordinate memory.
// Each endpoint then passes S_SWADDR, S_SWCODE, S_SWPROC; result stalls hold S_SWPROC.
// Reset is synchronous and active high; it empties the store and the result register.
module interval_graph_fvs_sweep #(
   parameter int MAX_INTERVALS = igfvs_pkg::MaxIntervals,
   parameter int COORD_WIDTH = igfvs_pkg::CoordWidth
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [COORD_WIDTH-1:0]        req_start_pos,
   input  logic [COORD_WIDTH-1:0]        req_end_pos,
   input  logic [igfvs_pkg::IdWidth-1:0] req_ident,
   input  logic                          req_final_item,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [igfvs_pkg::IdWidth-1:0] rsp_member_id,
   output logic                          rsp_empty_set,
   output logic                          rsp_overflow,
   output logic                          rsp_run_end
);
   import igfvs_pkg::*;

   cmd_type    cmd;
   status_type sts;

   igfvs_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_final_item (req_final_item),
      .req_stall      (req_stall),
      .sts            (sts),
      .cmd            (cmd)
   );

   igfvs_dp #(
      .MAX_INTERVALS (MAX_INTERVALS),
      .COORD_WIDTH   (COORD_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_start_pos  (req_start_pos),
      .req_end_pos    (req_end_pos),
      .req_ident      (req_ident),
      .req_final_item (req_final_item),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_member_id  (rsp_member_id),
      .rsp_empty_set  (rsp_empty_set),
      .rsp_overflow   (rsp_overflow),
      .rsp_run_end    (rsp_run_end)
   );

endmodule

### src/igfvs_checker.sv
module igfvs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [igfvs_pkg::IdWidth-1:0] rsp_member_id,
   input logic                          rsp_empty_set,
   input logic                          rsp_run_end
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_member_id))
      else $error("Stalled result transaction changed.");

   a_empty_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_set |-> rsp_run_end)
      else $error("Empty result is not the last of its run.");

   a_empty_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_set |-> rsp_member_id == '0)
      else $error("Empty result carries a nonzero id.");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result valid after reset.");

endmodule

bind interval_graph_fvs_sweep igfvs_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_member_id (rsp_member_id),
   .rsp_empty_set (rsp_empty_set),
   .rsp_run_end   (rsp_run_end)
);

### tb/interval_graph_fvs_sweep_tb.sv
`timescale 1ns / 1ps

module interval_graph_fvs_sweep_tb;

   localparam int NumSlots = igfvs_pkg::MaxIntervals;
   localparam int CoordBits = igfvs_pkg::CoordWidth;
   localparam int IdBits = igfvs_pkg::IdWidth;

   typedef struct {
      logic [IdBits-1:0] member_id;
      logic              empty_set;
      logic              overflow;
      logic              run_end;
   } member_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [CoordBits-1:0] req_start_pos;
   logic [CoordBits-1:0] req_end_pos;
   logic [IdBits-1:0]    req_ident;
   logic                 req_final_item;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [IdBits-1:0]    rsp_member_id;
   logic                 rsp_empty_set;
   logic                 rsp_overflow;
   logic                 rsp_run_end;

   member_type expected_members[$];
   int error_count = 0;
   int mismatch_count = 0;
   int result_count = 0;
   int interval_count = 0;
   int set_count = 0;
   int long_hold = 0;

   logic [CoordBits-1:0] held_start[NumSlots];
   logic [CoordBits-1:0] held_end[NumSlots];
   logic [IdBits-1:0]    held_ident[NumSlots];
   int                   held_count = 0;
   logic                 held_overflow = 1'b0;

   interval_graph_fvs_sweep DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_start_pos(req_start_pos),
      .req_end_pos(req_end_pos),
      .req_ident(req_ident),
      .req_final_item(req_final_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_member_id(rsp_member_id),
      .rsp_empty_set(rsp_empty_set),
      .rsp_overflow(rsp_overflow),
      .rsp_run_end(rsp_run_end)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("Timeout with %0d results still expected.", expected_members.size());
      $display("DONE: errors detected");
      $finish;
   end

   function automatic bit endpoint_first(int a, int b);
      logic [CoordBits-1:0] pa;
      logic [CoordBits-1:0] pb;
      pa = a[0] ? held_end[a >> 1] : held_start[a >> 1];
      pb = b[0] ? held_end[b >> 1] : held_start[b >> 1];
      if (pa != pb) return pa < pb;
      if (a[0] != b[0]) return a[0] < b[0];
      return (a >> 1) < (b >> 1);
   endfunction

   task automatic push_member(logic [IdBits-1:0] id, logic empty);
      member_type m;
      m.member_id = id;
      m.empty_set = empty;
      m.overflow = held_overflow;
      m.run_end = 1'b0;
      expected_members.insert(expected_members.size(), m);
   endtask

   task automatic predict_sweep();
      int rank[NumSlots];
      int order[2*NumSlots];
      int total;
      int first;
      int j;
      int c;
      int e;
      int lo;
      int hi;
      int t;
      bit lo_ok;
      bit hi_ok;
      total = 2 * held_count;
      first = expected_members.size();
      for (int i = 0; i < held_count; i++) begin
         rank[i] = 0;
         for (int k = 0; k < held_count; k++)
            if (held_end[k] < held_end[i] || (held_end[k] == held_end[i] && k < i))
               rank[i]++;
      end
      for (int i = 0; i < total; i++) begin
         c = i;
         j = i;
         while (j > 0 && endpoint_first(c, order[j-1])) begin
            order[j] = order[j-1];
            j--;
         end
         order[j] = c;
      end
      lo_ok = 0;
      hi_ok = 0;
      lo = 0;
      hi = 0;
      for (int i = 0; i < total; i++) begin
         e = order[i] >> 1;
         if (order[i][0] == 1'b0) begin
            if (!hi_ok) begin
               hi = e;
               hi_ok = 1;
            end else if (!lo_ok) begin
               lo = e;
               lo_ok = 1;
               if (rank[lo] > rank[hi]) begin
                  t = lo;
                  lo = hi;
                  hi = t;
               end
            end else if (rank[e] < rank[lo]) begin
               push_member(held_ident[hi], 1'b0);
               hi = lo;
               lo = e;
            end else if (rank[e] < rank[hi]) begin
               push_member(held_ident[hi], 1'b0);
               hi = e;
            end else begin
               push_member(held_ident[e], 1'b0);
            end
         end else begin
            if (lo_ok && lo == e) lo_ok = 0;
            if (hi_ok && hi == e) hi_ok = 0;
            if (lo_ok && !hi_ok) begin
               hi = lo;
               hi_ok = 1;
               lo_ok = 0;
            end
         end
      end
      if (expected_members.size() == first) push_member('0, 1'b1);
      expected_members[expected_members.size()-1].run_end = 1'b1;
   endtask

   task automatic send_interval(logic [CoordBits-1:0] s, logic [CoordBits-1:0] f,
                                logic [IdBits-1:0] id, logic last);
      if (held_count < NumSlots) begin
         held_start[held_count] = s;
         held_end[held_count] = f;
         held_ident[held_count] = id;
         held_count++;
      end else begin
         held_overflow = 1'b1;
      end
      if (last) begin
         predict_sweep();
         held_count = 0;
         held_overflow = 1'b0;
         set_count++;
      end
      interval_count++;
      req_valid <= 1'b1;
      req_start_pos <= s;
      req_end_pos <= f;
      req_ident <= id;
      req_final_item <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      if ($urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         req_start_pos <= CoordBits'($urandom);
         req_end_pos <= CoordBits'($urandom);
         repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 30) : $urandom_range(1, 2))
            @(negedge clock);
      end
   endtask

   task automatic send_random_interval(logic last, int span);
      logic [CoordBits-1:0] s;
      logic [CoordBits-1:0] w;
      s = CoordBits'($urandom_range(0, 65535 - span));
      w = CoordBits'($urandom_range(1, span));
      if ($urandom_range(0, 19) == 0) send_interval(CoordBits'($urandom), CoordBits'($urandom),
                                                    IdBits'($urandom), last);
      else send_interval(s, s + w, IdBits'($urandom), last);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (req_valid || expected_members.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic test_directed();
      send_interval(16'd5, 16'd9, 10'd1, 1'b1);
      send_interval(16'd0, 16'd10, 10'd2, 1'b0);
      send_interval(16'd1, 16'd11, 10'd3, 1'b0);
      send_interval(16'd2, 16'd12, 10'd4, 1'b1);
      send_interval(16'd0, 16'hFFFF, 10'h3FF, 1'b0);
      send_interval(16'd100, 16'd200, 10'd0, 1'b0);
      send_interval(16'd150, 16'd200, 10'h2AA, 1'b0);
      send_interval(16'd50, 16'd60, 10'h155, 1'b1);
      send_interval(16'd10, 16'd20, 10'd7, 1'b0);
      send_interval(16'd20, 16'd30, 10'd8, 1'b0);
      send_interval(16'd20, 16'd30, 10'd9, 1'b0);
      send_interval(16'd40, 16'd5, 10'd10, 1'b0);
      send_interval(16'd41, 16'd45, 10'd11, 1'b0);
      send_interval(16'd42, 16'd46, 10'd12, 1'b1);
      send_interval(16'hFFFF, 16'd0, 10'd13, 1'b1);
   endtask

   task automatic test_overflow();
      for (int i = 0; i < NumSlots + 3; i++)
         send_interval(CoordBits'(i), CoordBits'(i + 1000), IdBits'(i), i == NumSlots + 2);
      for (int i = 0; i < NumSlots; i++) send_random_interval(i == NumSlots - 1, 3000);
   endtask

   task automatic test_back_pressure();
      long_hold = 2000;
      for (int i = 0; i < 12; i++) send_random_interval(i == 11, 20000);
      for (int i = 0; i < 8; i++) send_random_interval(i == 7, 20000);
   endtask

   task automatic test_random_sets();
      int n;
      while (interval_count < 430) begin
         n = ($urandom_range(0, 15) == 0) ? NumSlots : $urandom_range(1, 8);
         for (int i = 0; i < n; i++) send_random_interval(i == n - 1, 20000);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_start_pos = '0;
      req_end_pos = '0;
      req_ident = '0;
      req_final_item = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_overflow();
      test_back_pressure();
      test_random_sets();
      drain();
      $display("Covered %0d intervals in %0d sets, %0d members checked.",
               interval_count, set_count, result_count);
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (long_hold) @(negedge clock);
            long_hold = 0;
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 40) : 1) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         if ($urandom_range(0, 7) == 0) repeat ($urandom_range(10, 40)) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      member_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         result_count++;
         if (expected_members.size() == 0) begin
            error_count++;
            $display("Unexpected member result id=%0d", rsp_member_id);
         end else begin
            want = expected_members.pop_front();
            if (rsp_member_id !== want.member_id || rsp_empty_set !== want.empty_set ||
                rsp_overflow !== want.overflow || rsp_run_end !== want.run_end) begin
               error_count++;
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Mismatch: expected id=%0d empty=%0b ovf=%0b end=%0b, got %0d %0b %0b %0b",
                           want.member_id, want.empty_set, want.overflow, want.run_end,
                           rsp_member_id, rsp_empty_set, rsp_overflow, rsp_run_end);
            end
         end
      end
   end

endmodule

### sim.f
src/igfvs_pkg.sv
src/igfvs_ctrl.sv
src/igfvs_dp.sv
src/interval_graph_fvs_sweep.sv
src/igfvs_checker.sv
tb/interval_graph_fvs_sweep_tb.sv
